// ===== hw/rtl/teq_pkg.sv =====
package teq_pkg;

    localparam int READY_DEPTH = 64;
    localparam int SCHED_DEPTH = 32;
    localparam int RA_W = $clog2(READY_DEPTH);
    localparam int RC_W = $clog2(READY_DEPTH + 1);
    localparam int SA_W = $clog2(SCHED_DEPTH);
    localparam int SC_W = $clog2(SCHED_DEPTH + 1);
    localparam int REC_W = 32 * 4 + 64;
    localparam logic [31:0] WINDOW_RESET = 32'd100;

    typedef enum logic [2:0] {
        OP_POST   = 3'd0,
        OP_SCHED  = 3'd1,
        OP_TICK   = 3'd2,
        OP_TAKE   = 3'd3,
        OP_PEEK   = 3'd4,
        OP_UNSCH  = 3'd5,
        OP_RESCH  = 3'd6,
        OP_CLEAR  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_INDEX = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_ID   = 3'd3,
        ST_DISABLED = 3'd4
    } t_status;

    localparam logic [0:0] CFG_WINDOW = 1'b0;
    localparam logic [0:0] CFG_ENABLE = 1'b1;

    // Event record: code, three args, time.
    typedef struct packed {
        logic [31:0] code;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [63:0] t;
    } t_rec;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_TAKE_RD,
        S_TAKE_WR,
        S_FREE_SCAN,
        S_INS_RD,
        S_INS_CMP,
        S_INS_DONE,
        S_UNL_RD,
        S_UNL_CMP,
        S_UNL_DONE,
        S_RESCH_PUT,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_PUSH,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/timed_event_queue_unit.sv =====
// Timed event queue: a ready list of 64 events and a time-sorted list of 32
// scheduled events (linked slots, id = slot + 1). One operation at a time;
// input is taken only while idle with no result waiting. A sequencer runs
// each operation over single-port-write, registered-read memories: take
// shifts the tail down one entry per pass of a read and a write state;
// schedule scans free slots one per cycle and walks the sorted chain through
// a read and a compare state per link; unschedule walks the chain likewise;
// a tick reads, checks and pushes each moved event in turn.
module timed_event_queue_unit
    import teq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_opcode,
    input  logic [63:0]       i_now_time,
    input  logic [63:0]       i_at_time,
    input  logic [31:0]       i_event_code,
    input  logic signed [31:0] i_arg_a,
    input  logic signed [31:0] i_arg_b,
    input  logic signed [31:0] i_arg_c,
    input  logic [5:0]        i_item_index,
    input  logic [5:0]        i_event_id,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_status,
    output logic [31:0]       o_out_code,
    output logic signed [31:0] o_out_a,
    output logic signed [31:0] o_out_b,
    output logic signed [31:0] o_out_c,
    output logic [63:0]       o_out_time,
    output logic [5:0]        o_out_id,
    output logic [6:0]        o_ready_total,
    output logic [5:0]        o_sched_total,
    output logic [5:0]        o_moved_total
);
    // Configuration.
    logic [31:0] r_window;
    logic        r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW: r_window <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stores.
    logic            rr_we;
    logic [RA_W-1:0] rr_waddr, rr_raddr;
    t_rec            rr_wdata, rr_rdata;
    logic            sr_we;
    logic [SA_W-1:0] sr_waddr, sr_raddr;
    t_rec            sr_wdata, sr_rdata;
    logic            lk_we;
    logic [SA_W-1:0] lk_waddr, lk_raddr;
    logic [SA_W:0]   lk_wdata, lk_rdata;

    teq_ram #(.WIDTH(REC_W), .DEPTH(READY_DEPTH)) u_ready (
        .i_clk(i_clk), .i_we(rr_we), .i_waddr(rr_waddr), .i_wdata(rr_wdata),
        .i_raddr(rr_raddr), .o_rdata(rr_rdata));
    teq_ram #(.WIDTH(REC_W), .DEPTH(SCHED_DEPTH)) u_slots (
        .i_clk(i_clk), .i_we(sr_we), .i_waddr(sr_waddr), .i_wdata(sr_wdata),
        .i_raddr(sr_raddr), .o_rdata(sr_rdata));
    teq_ram #(.WIDTH(SA_W + 1), .DEPTH(SCHED_DEPTH)) u_links (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata));

    // Control and working registers.
    t_state            r_state, n_state;
    logic [RC_W-1:0]   r_rcnt, n_rcnt;
    logic [SC_W-1:0]   r_scnt, n_scnt;
    logic [SCHED_DEPTH-1:0] r_svalid, n_svalid;
    logic [SA_W:0]     r_head, n_head;
    t_op               r_op, n_op;
    logic [63:0]       r_now, n_now, r_at, n_at;
    t_rec              r_rec, n_rec;
    logic [RA_W-1:0]   r_idx, n_idx;
    logic [SA_W:0]     r_slot, n_slot;
    logic [SA_W:0]     r_prev, n_prev, r_cur, n_cur;
    logic [63:0]       r_et, n_et;
    logic [2:0]        r_st, n_st;
    logic [5:0]        r_oid, n_oid, r_moved, n_moved;
    logic [63:0]       r_otime, n_otime;
    t_rec              r_orec, n_orec;
    logic              r_ovalid, n_ovalid;

    localparam logic [SA_W:0] NONE = (SA_W + 1)'(SCHED_DEPTH);

    logic [63:0] w_diff;
    logic        w_ready_full;
    assign w_diff       = sr_rdata.t - r_et;
    assign w_ready_full = (r_rcnt == RC_W'(READY_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rcnt   <= '0;
            r_scnt   <= '0;
            r_svalid <= '0;
            r_head   <= NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rcnt   <= n_rcnt;
            r_scnt   <= n_scnt;
            r_svalid <= n_svalid;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op; r_now <= n_now; r_at <= n_at; r_rec <= n_rec;
        r_idx <= n_idx; r_slot <= n_slot; r_prev <= n_prev; r_cur <= n_cur;
        r_et <= n_et; r_st <= n_st; r_oid <= n_oid; r_moved <= n_moved;
        r_otime <= n_otime; r_orec <= n_orec;
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;

    // Sequencer.
    always_comb begin
        n_state = r_state; n_rcnt = r_rcnt; n_scnt = r_scnt; n_svalid = r_svalid;
        n_head = r_head; n_op = r_op; n_now = r_now; n_at = r_at; n_rec = r_rec;
        n_idx = r_idx; n_slot = r_slot; n_prev = r_prev; n_cur = r_cur;
        n_et = r_et; n_st = r_st; n_oid = r_oid; n_moved = r_moved;
        n_otime = r_otime; n_orec = r_orec; n_ovalid = r_ovalid;
        rr_we = 1'b0; rr_waddr = r_rcnt[RA_W-1:0]; rr_wdata = r_rec; rr_raddr = r_idx;
        sr_we = 1'b0; sr_waddr = r_slot[SA_W-1:0]; sr_wdata = r_rec;
        sr_raddr = r_cur[SA_W-1:0];
        lk_we = 1'b0; lk_waddr = r_slot[SA_W-1:0]; lk_wdata = r_cur;
        lk_raddr = r_cur[SA_W-1:0];

        if (r_ovalid && !i_stall) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_op = t_op'(i_opcode);
                    n_now = i_now_time; n_at = i_at_time;
                    n_rec = '{code: i_event_code, a: i_arg_a, b: i_arg_b,
                              c: i_arg_c, t: i_now_time};
                    n_idx = i_item_index;
                    n_slot = i_event_id[SA_W:0] - 1'b1;
                    n_st = ST_OK; n_oid = '0; n_moved = '0; n_otime = '0;
                    n_orec = '0;
                    n_state = S_DISPATCH;
                    if (i_event_id == 6'd0 || i_event_id > 6'(SCHED_DEPTH))
                        n_slot = NONE;
                end
            end
            S_DISPATCH: begin
                unique case (r_op)
                    OP_POST: begin
                        if (w_ready_full) n_st = ST_FULL;
                        else begin
                            rr_we = 1'b1; n_rcnt = r_rcnt + 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    OP_SCHED: begin
                        if (!r_enable) begin
                            n_st = ST_DISABLED; n_state = S_OUT;
                        end else if (r_now < r_at) begin
                            n_rec.t = r_at; n_slot = '0; n_state = S_FREE_SCAN;
                        end else begin
                            if (w_ready_full) n_st = ST_FULL;
                            else begin
                                rr_we = 1'b1;
                                rr_wdata.t = (r_at != 0) ? r_at : r_now;
                                n_rcnt = r_rcnt + 1'b1;
                            end
                            n_state = S_OUT;
                        end
                    end
                    OP_TICK: begin
                        n_cur = r_head;
                        if (r_head == NONE) n_state = S_OUT;
                        else n_state = S_TICK_RD;
                    end
                    OP_TAKE, OP_PEEK: begin
                        if ({1'b0, r_idx} >= r_rcnt) begin
                            n_st = ST_NO_INDEX; n_state = S_OUT;
                        end else n_state = S_RD_WAIT;
                    end
                    OP_UNSCH, OP_RESCH: begin
                        // Fetch the addressed slot record.
                        sr_raddr = r_slot[SA_W-1:0];
                        if (r_slot == NONE || !r_svalid[r_slot[SA_W-1:0]]) begin
                            n_st = ST_BAD_ID; n_state = S_OUT;
                        end else if (r_op == OP_RESCH && !(r_now < r_at)
                                     && w_ready_full) begin
                            n_st = ST_FULL; n_state = S_OUT;
                        end else begin
                            n_cur = r_slot; n_state = S_RD_WAIT;
                        end
                    end
                    default: begin
                        n_rcnt = '0; n_state = S_OUT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                // Registered read of ready entry or slot is now present.
                if (r_op == OP_TAKE || r_op == OP_PEEK) begin
                    n_orec = rr_rdata; n_otime = rr_rdata.t;
                    if (r_op == OP_PEEK) n_state = S_OUT;
                    else begin
                        n_idx = r_idx + 1'b1; rr_raddr = r_idx + 1'b1;
                        n_state = S_TAKE_RD;
                    end
                end else begin
                    n_orec = sr_rdata; n_otime = sr_rdata.t; n_rec = sr_rdata;
                    n_prev = NONE; n_cur = r_head; lk_raddr = r_head[SA_W-1:0];
                    n_state = S_UNL_RD;
                end
            end
            S_TAKE_RD: begin
                // Shift the tail down one entry per pass.
                if ({1'b0, r_idx} >= r_rcnt || r_idx == '0) begin
                    n_rcnt = r_rcnt - 1'b1; n_state = S_OUT;
                end else n_state = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                rr_we = 1'b1; rr_waddr = r_idx - 1'b1; rr_wdata = rr_rdata;
                n_idx = r_idx + 1'b1; rr_raddr = r_idx + 1'b1;
                n_state = S_TAKE_RD;
            end
            S_FREE_SCAN: begin
                if (r_slot == NONE) begin
                    n_st = ST_FULL; n_state = S_OUT;
                end else if (!r_svalid[r_slot[SA_W-1:0]]) begin
                    sr_we = 1'b1;
                    n_prev = NONE; n_cur = r_head; sr_raddr = r_head[SA_W-1:0];
                    lk_raddr = r_head[SA_W-1:0];
                    n_state = S_INS_RD;
                end else n_slot = r_slot + 1'b1;
            end
            S_INS_RD: begin
                n_state = (r_cur == NONE) ? S_INS_DONE : S_INS_CMP;
            end
            S_INS_CMP: begin
                // Walk while the chain time is below the new time.
                if (sr_rdata.t < r_rec.t) begin
                    n_prev = r_cur; n_cur = lk_rdata;
                    sr_raddr = lk_rdata[SA_W-1:0]; lk_raddr = lk_rdata[SA_W-1:0];
                    n_state = S_INS_RD;
                end else n_state = S_INS_DONE;
            end
            S_INS_DONE: begin
                lk_we = 1'b1;
                n_state = S_RESCH_PUT;
                n_svalid[r_slot[SA_W-1:0]] = 1'b1;
                n_scnt = r_scnt + 1'b1;
                n_oid = 6'(r_slot) + 6'd1;
                if (r_prev == NONE) n_head = r_slot;
                if (r_op == OP_RESCH) n_otime = r_rec.t;
            end
            S_RESCH_PUT: begin
                // Second link write: predecessor points at the new slot.
                if (r_prev != NONE) begin
                    lk_we = 1'b1; lk_waddr = r_prev[SA_W-1:0]; lk_wdata = r_slot;
                end
                n_state = S_OUT;
            end
            S_UNL_RD: begin
                n_state = S_UNL_CMP;
            end
            S_UNL_CMP: begin
                if (r_cur == r_slot) n_state = S_UNL_DONE;
                else begin
                    n_prev = r_cur; n_cur = lk_rdata;
                    lk_raddr = lk_rdata[SA_W-1:0]; n_state = S_UNL_RD;
                end
            end
            S_UNL_DONE: begin
                // lk_rdata holds the successor of the removed slot.
                if (r_prev == NONE) n_head = lk_rdata;
                else begin
                    lk_we = 1'b1; lk_waddr = r_prev[SA_W-1:0]; lk_wdata = lk_rdata;
                end
                n_svalid[r_slot[SA_W-1:0]] = 1'b0;
                n_scnt = r_scnt - 1'b1;
                n_state = S_OUT;
                if (r_op == OP_RESCH) begin
                    if (r_now < r_at) begin
                        n_rec.t = r_at;
                        n_state = S_FREE_SCAN;
                        n_svalid[r_slot[SA_W-1:0]] = 1'b0;
                    end else begin
                        n_otime = (r_at != 0) ? r_at : r_now;
                        rr_we = 1'b1; rr_wdata.t = (r_at != 0) ? r_at : r_now;
                        n_rcnt = r_rcnt + 1'b1;
                    end
                end
            end
            S_TICK_RD: begin
                n_state = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                if (r_cur == NONE) n_state = S_OUT;
                else if (r_moved == '0 && sr_rdata.t > r_now) n_state = S_OUT;
                else if (r_moved != '0 && w_diff > {32'd0, r_window}) n_state = S_OUT;
                else if (w_ready_full) begin
                    n_st = ST_FULL; n_state = S_OUT;
                end else begin
                    if (r_moved == '0) n_et = sr_rdata.t;
                    n_state = S_TICK_PUSH;
                end
            end
            S_TICK_PUSH: begin
                // Move head to the ready list and advance the head.
                rr_we = 1'b1; rr_wdata = sr_rdata; n_rcnt = r_rcnt + 1'b1;
                n_svalid[r_cur[SA_W-1:0]] = 1'b0;
                n_scnt = r_scnt - 1'b1;
                n_moved = r_moved + 1'b1;
                n_head = lk_rdata; n_cur = lk_rdata;
                sr_raddr = lk_rdata[SA_W-1:0]; lk_raddr = lk_rdata[SA_W-1:0];
                n_state = S_TICK_RD;
            end
            S_OUT: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
                if (r_st != ST_OK) begin
                    n_orec = '0; n_otime = '0; n_oid = '0;
                end
                if (r_op == OP_UNSCH || r_op == OP_TAKE || r_op == OP_PEEK
                    || r_op == OP_RESCH) begin
                end else begin
                    n_orec = '0; n_otime = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_st;
    assign o_out_code    = r_orec.code;
    assign o_out_a       = r_orec.a;
    assign o_out_b       = r_orec.b;
    assign o_out_c       = r_orec.c;
    assign o_out_time    = r_otime;
    assign o_out_id      = r_oid;
    assign o_ready_total = 7'(r_rcnt);
    assign o_sched_total = 6'(r_scnt);
    assign o_moved_total = r_moved;
endmodule

// ===== hw/rtl/teq_ram.sv =====
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
